/* design/cvar_pkg.sv */
// Shared codes and fixed field widths for the consensus vote and append responder.
package cvar_pkg;

  localparam int REF_INDEX_W  = 11;
  localparam int LOG_LEN_W    = 11;
  localparam int ENTRY_DATA_W = 64;
  localparam int ROLE_W       = 2;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_VOTE   = 1'b1;

  localparam logic [ROLE_W-1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_LEADER    = 2'd2;

endpackage

/* design/consensus_vote_and_append_responder_top.sv */
// Consensus vote and append request responder: term, vote and bounded entry log.
//
// Takes one vote or append request per beat and returns one reply beat. Each request
// passes through capture, a term check against the current term, a registered read
// of the log term memory at the last or previous index, and the judgment, which writes
// an accepted entry and loads the reply register. The input is stalled from capture until
// the judgment; a reply that waits on a stalled output holds the judgment step. One
// magnitude comparator serves both the term check and the log term check. The log
// memories need no clearing after reset: only entries below the fill count are ever used.
// Role code 3 on the input is taken as follower.
module consensus_vote_and_append_responder_top #(
  parameter int LOG_DEPTH    = 1024,
  parameter int TERM_BITS    = 32,
  parameter int PEER_ID_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_req_type,
  input  logic [TERM_BITS-1:0]                   in_req_term,
  input  logic [PEER_ID_BITS-1:0]                in_peer_id,
  input  logic signed [cvar_pkg::REF_INDEX_W-1:0] in_ref_index,
  input  logic [TERM_BITS-1:0]                   in_ref_term,
  input  logic                                   in_has_entry,
  input  logic [TERM_BITS-1:0]                   in_entry_term,
  input  logic [cvar_pkg::ENTRY_DATA_W-1:0]      in_entry_data,
  input  logic [cvar_pkg::ROLE_W-1:0]            in_current_role,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [TERM_BITS-1:0]                   out_reply_term,
  output logic                                   out_success,
  output logic [cvar_pkg::ROLE_W-1:0]            out_new_role,
  output logic                                   out_heartbeat_seen,
  output logic [cvar_pkg::LOG_LEN_W-1:0]         out_log_length,
  output logic                                   out_log_full
);
  import cvar_pkg::*;

  localparam int LW = $clog2(LOG_DEPTH + 1);
  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = (LW > REF_INDEX_W) ? LW : REF_INDEX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TERM,
    S_READ,
    S_JUDGE
  } state_t;

  state_t state_r, state_nxt;

  // control state
  logic [TERM_BITS-1:0]    term_now_r, term_now_nxt;
  logic                    vote_cast_r, vote_cast_nxt;
  logic [PEER_ID_BITS-1:0] vote_target_r, vote_target_nxt;
  logic [LW-1:0]           held_r, held_nxt;
  logic                    stale_r, stale_nxt;

  // captured request
  logic                          req_type_r, req_type_nxt;
  logic [TERM_BITS-1:0]          req_term_r, req_term_nxt;
  logic [PEER_ID_BITS-1:0]       peer_r, peer_nxt;
  logic signed [REF_INDEX_W-1:0] ref_index_r, ref_index_nxt;
  logic [TERM_BITS-1:0]          ref_term_r, ref_term_nxt;
  logic                          has_entry_r, has_entry_nxt;
  logic [TERM_BITS-1:0]          entry_term_r, entry_term_nxt;
  logic [ENTRY_DATA_W-1:0]       entry_data_r, entry_data_nxt;
  logic [ROLE_W-1:0]             role_r, role_nxt;
  logic [AW-1:0]                 rd_addr_r, rd_addr_nxt;

  // reply register
  logic                 out_valid_r, out_valid_nxt;
  logic [TERM_BITS-1:0] out_reply_term_r, out_reply_term_nxt;
  logic                 out_success_r, out_success_nxt;
  logic [ROLE_W-1:0]    out_new_role_r, out_new_role_nxt;
  logic                 out_heartbeat_r, out_heartbeat_nxt;
  logic [LOG_LEN_W-1:0] out_log_length_r, out_log_length_nxt;
  logic                 out_log_full_r, out_log_full_nxt;

  // log memories
  logic [TERM_BITS-1:0]    term_mem [LOG_DEPTH];
  logic [ENTRY_DATA_W-1:0] data_mem [LOG_DEPTH];
  logic [TERM_BITS-1:0]    rd_term_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;

  // shared comparator
  logic [TERM_BITS-1:0] cmp_a, cmp_b;
  logic                 cmp_lt, cmp_eq;

  // index arithmetic
  logic [REF_INDEX_W-1:0] plen;
  logic                   plen_ok;
  logic [CW-1:0]          plen_ext, plen_dec, plen_inc, held_ext, len_ext;
  logic [LW-1:0]          held_dec;
  logic                   out_free;

  logic                   ok, hb, full;
  logic [ROLE_W-1:0]      rl;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (state_r == S_TERM) begin
      cmp_a = req_term_r;
      cmp_b = term_now_r;
    end else begin
      cmp_a = rd_term_r;
      cmp_b = ref_term_r;
    end
  end
  assign cmp_lt = (cmp_a < cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

  // peer log length is ref_index + 1; below -1 is malformed
  assign plen     = $unsigned(ref_index_r) + REF_INDEX_W'(1);
  assign plen_ok  = !(ref_index_r[REF_INDEX_W-1] && !(&ref_index_r[REF_INDEX_W-2:0]));
  assign plen_ext = CW'(plen);
  assign plen_dec = plen_ext - CW'(1);
  assign plen_inc = plen_ext + CW'(1);
  assign held_ext = CW'(held_r);
  assign held_dec = held_r - LW'(1);

  always_comb begin
    state_nxt          = state_r;
    term_now_nxt       = term_now_r;
    vote_cast_nxt      = vote_cast_r;
    vote_target_nxt    = vote_target_r;
    held_nxt           = held_r;
    stale_nxt          = stale_r;
    req_type_nxt       = req_type_r;
    req_term_nxt       = req_term_r;
    peer_nxt           = peer_r;
    ref_index_nxt      = ref_index_r;
    ref_term_nxt       = ref_term_r;
    has_entry_nxt      = has_entry_r;
    entry_term_nxt     = entry_term_r;
    entry_data_nxt     = entry_data_r;
    role_nxt           = role_r;
    rd_addr_nxt        = rd_addr_r;
    out_valid_nxt      = out_valid_r;
    out_reply_term_nxt = out_reply_term_r;
    out_success_nxt    = out_success_r;
    out_new_role_nxt   = out_new_role_r;
    out_heartbeat_nxt  = out_heartbeat_r;
    out_log_length_nxt = out_log_length_r;
    out_log_full_nxt   = out_log_full_r;
    mem_we             = 1'b0;
    mem_wa             = plen_ext[AW-1:0];
    ok                 = 1'b0;
    hb                 = 1'b0;
    full               = 1'b0;
    rl                 = role_r;
    len_ext            = CW'(held_r);

    // drop the reply once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_type_nxt   = in_req_type;
          req_term_nxt   = in_req_term;
          peer_nxt       = in_peer_id;
          ref_index_nxt  = in_ref_index;
          ref_term_nxt   = in_ref_term;
          has_entry_nxt  = in_has_entry;
          entry_term_nxt = in_entry_term;
          entry_data_nxt = in_entry_data;
          role_nxt       = (in_current_role > ROLE_LEADER) ? ROLE_FOLLOWER : in_current_role;
          state_nxt      = S_TERM;
        end
      end
      S_TERM: begin
        stale_nxt = cmp_lt;
        // adopt a newer term and clear the vote
        if (!cmp_lt && !cmp_eq) begin
          term_now_nxt    = req_term_r;
          vote_cast_nxt   = 1'b0;
          vote_target_nxt = '0;
          role_nxt        = ROLE_FOLLOWER;
        end
        rd_addr_nxt = (req_type_r == REQ_VOTE) ? held_dec[AW-1:0] : plen_dec[AW-1:0];
        state_nxt   = S_READ;
      end
      S_READ: begin
        state_nxt = S_JUDGE;
      end
      S_JUDGE: begin
        if (out_free) begin
          if (!stale_r) begin
            if (req_type_r == REQ_VOTE) begin
              if (vote_cast_r) begin
                if (vote_target_r == peer_r) begin
                  ok = 1'b1;
                  rl = ROLE_FOLLOWER;
                end
              end else if ((held_r == '0) || cmp_lt ||
                           (cmp_eq && plen_ok && (plen_ext >= held_ext))) begin
                vote_cast_nxt   = 1'b1;
                vote_target_nxt = peer_r;
                ok              = 1'b1;
                rl              = ROLE_FOLLOWER;
              end
            end else begin
              rl = ROLE_FOLLOWER;
              hb = 1'b1;
              if (plen_ok && (plen_ext <= held_ext)) begin
                // cut a longer local log back to the peer's length
                held_nxt = LW'(plen_ext);
                if ((plen_ext == '0) || cmp_eq) begin
                  ok = 1'b1;
                  if (has_entry_r) begin
                    if (plen_ext >= CW'(LOG_DEPTH)) begin
                      ok   = 1'b0;
                      full = 1'b1;
                    end else begin
                      mem_we   = 1'b1;
                      held_nxt = LW'(plen_inc);
                    end
                  end
                end
              end
            end
          end
          len_ext            = CW'(held_nxt);
          out_valid_nxt      = 1'b1;
          out_reply_term_nxt = term_now_r;
          out_success_nxt    = ok;
          out_new_role_nxt   = rl;
          out_heartbeat_nxt  = hb;
          out_log_length_nxt = len_ext[LOG_LEN_W-1:0];
          out_log_full_nxt   = full;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      term_now_r    <= '0;
      vote_cast_r   <= 1'b0;
      vote_target_r <= '0;
      held_r        <= '0;
      stale_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      term_now_r    <= term_now_nxt;
      vote_cast_r   <= vote_cast_nxt;
      vote_target_r <= vote_target_nxt;
      held_r        <= held_nxt;
      stale_r       <= stale_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    req_type_r       <= req_type_nxt;
    req_term_r       <= req_term_nxt;
    peer_r           <= peer_nxt;
    ref_index_r      <= ref_index_nxt;
    ref_term_r       <= ref_term_nxt;
    has_entry_r      <= has_entry_nxt;
    entry_term_r     <= entry_term_nxt;
    entry_data_r     <= entry_data_nxt;
    role_r           <= role_nxt;
    rd_addr_r        <= rd_addr_nxt;
    out_reply_term_r <= out_reply_term_nxt;
    out_success_r    <= out_success_nxt;
    out_new_role_r   <= out_new_role_nxt;
    out_heartbeat_r  <= out_heartbeat_nxt;
    out_log_length_r <= out_log_length_nxt;
    out_log_full_r   <= out_log_full_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      term_mem[mem_wa] <= entry_term_r;
      data_mem[mem_wa] <= entry_data_r;
    end
    rd_term_r <= term_mem[rd_addr_r];
  end

  assign out_valid          = out_valid_r;
  assign out_reply_term     = out_reply_term_r;
  assign out_success        = out_success_r;
  assign out_new_role       = out_new_role_r;
  assign out_heartbeat_seen = out_heartbeat_r;
  assign out_log_length     = out_log_length_r;
  assign out_log_full       = out_log_full_r;

endmodule

/* test/consensus_vote_and_append_responder_top_tb.sv */
// Self-checking testbench for the consensus vote and append responder.
`timescale 1ns / 1ps

module consensus_vote_and_append_responder_top_tb;
  import cvar_pkg::*;

  localparam int LOG_DEPTH   = 1024;
  localparam int TERM_W      = 32;
  localparam int PEER_W      = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic                          req_type;
    logic [TERM_W-1:0]             req_term;
    logic [PEER_W-1:0]             peer_id;
    logic signed [REF_INDEX_W-1:0] ref_index;
    logic [TERM_W-1:0]             ref_term;
    logic                          has_entry;
    logic [TERM_W-1:0]             entry_term;
    logic [ENTRY_DATA_W-1:0]       entry_data;
    logic [ROLE_W-1:0]             current_role;
  } request_t;

  typedef struct packed {
    logic [TERM_W-1:0]    reply_term;
    logic                 success;
    logic [ROLE_W-1:0]    new_role;
    logic                 heartbeat_seen;
    logic [LOG_LEN_W-1:0] log_length;
    logic                 log_full;
  } reply_t;

  class rpc_scoreboard;
    bit [TERM_W-1:0] term_now;
    bit              vote_cast;
    bit [PEER_W-1:0] vote_target;
    int              held;
    bit [TERM_W-1:0] log_terms [LOG_DEPTH];
    reply_t          replies_due [$];
    int              errors;

    function bit [TERM_W-1:0] last_term();
      return (held == 0) ? '0 : log_terms[held-1];
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction

    // Advance the follower state by one request and queue its reply.
    function void note_request(request_t r);
      reply_t            exp;
      logic [ROLE_W-1:0] role;
      int                peer_len;
      bit                grant;
      bit                accept;
      exp = '0;
      role = (r.current_role > ROLE_LEADER) ? ROLE_FOLLOWER : r.current_role;
      peer_len = $signed(r.ref_index) + 1;
      if (r.req_term >= term_now) begin
        if (r.req_term > term_now) begin
          term_now = r.req_term;
          vote_cast = 1'b0;
          vote_target = '0;
          role = ROLE_FOLLOWER;
        end
        if (r.req_type == REQ_VOTE) begin
          if (vote_cast) begin
            if (vote_target == r.peer_id) begin
              exp.success = 1'b1;
              role = ROLE_FOLLOWER;
            end
          end else begin
            grant = (held == 0) || (last_term() < r.ref_term) ||
                    (last_term() == r.ref_term && peer_len >= held);
            if (grant) begin
              vote_cast = 1'b1;
              vote_target = r.peer_id;
              exp.success = 1'b1;
              role = ROLE_FOLLOWER;
            end
          end
        end else begin
          accept = 1'b0;
          role = ROLE_FOLLOWER;
          exp.heartbeat_seen = 1'b1;
          if (peer_len >= 0 && held >= peer_len) begin
            held = peer_len;
            accept = (peer_len == 0) || (log_terms[peer_len-1] == r.ref_term);
          end
          if (accept) begin
            exp.success = 1'b1;
            if (r.has_entry) begin
              if (held >= LOG_DEPTH) begin
                exp.success = 1'b0;
                exp.log_full = 1'b1;
              end else begin
                log_terms[held] = r.entry_term;
                held++;
              end
            end
          end
        end
      end
      exp.reply_term = term_now;
      exp.new_role = role;
      exp.log_length = LOG_LEN_W'(held);
      replies_due.push_back(exp);
    endfunction

    function void check_reply(reply_t got);
      reply_t exp;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: reply beat with no request outstanding: %p", $realtime, got);
        return;
      end
      exp = replies_due.pop_front();
      if (got.reply_term !== exp.reply_term || got.success !== exp.success ||
          got.new_role !== exp.new_role || got.heartbeat_seen !== exp.heartbeat_seen ||
          got.log_length !== exp.log_length || got.log_full !== exp.log_full) begin
        errors++;
        if (errors <= 10) begin
          $write("%0t: reply mismatch (exp/got): term %0h/%0h ok %b/%b role %0d/%0d",
                 $realtime, exp.reply_term, got.reply_term, exp.success, got.success,
                 exp.new_role, got.new_role);
          $display(" hb %b/%b len %0d/%0d full %b/%b", exp.heartbeat_seen,
                   got.heartbeat_seen, exp.log_length, got.log_length, exp.log_full,
                   got.log_full);
        end
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_req_type = 1'b0;
  logic [TERM_W-1:0]             in_req_term = '0;
  logic [PEER_W-1:0]             in_peer_id = '0;
  logic signed [REF_INDEX_W-1:0] in_ref_index = '0;
  logic [TERM_W-1:0]             in_ref_term = '0;
  logic                          in_has_entry = 1'b0;
  logic [TERM_W-1:0]             in_entry_term = '0;
  logic [ENTRY_DATA_W-1:0]       in_entry_data = '0;
  logic [ROLE_W-1:0]             in_current_role = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [TERM_W-1:0]             out_reply_term;
  logic                          out_success;
  logic [ROLE_W-1:0]             out_new_role;
  logic                          out_heartbeat_seen;
  logic [LOG_LEN_W-1:0]          out_log_length;
  logic                          out_log_full;

  rpc_scoreboard sb;
  int send_idle_pct = 8;
  int recv_idle_pct = 47;
  bit hold_start = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  consensus_vote_and_append_responder_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_req_term        (in_req_term),
    .in_peer_id         (in_peer_id),
    .in_ref_index       (in_ref_index),
    .in_ref_term        (in_ref_term),
    .in_has_entry       (in_has_entry),
    .in_entry_term      (in_entry_term),
    .in_entry_data      (in_entry_data),
    .in_current_role    (in_current_role),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_reply_term     (out_reply_term),
    .out_success        (out_success),
    .out_new_role       (out_new_role),
    .out_heartbeat_seen (out_heartbeat_seen),
    .out_log_length     (out_log_length),
    .out_log_full       (out_log_full)
  );

  always #5 clk = ~clk;

  // Receiver: random stall, or a long hold-off when the main process asks for one.
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_reply({out_reply_term, out_success, out_new_role, out_heartbeat_seen,
                      out_log_length, out_log_full});
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic request_t make_req(bit t, bit [TERM_W-1:0] term, bit [PEER_W-1:0] peer,
                                        int idx, bit [TERM_W-1:0] rterm, bit has,
                                        bit [TERM_W-1:0] eterm, bit [ENTRY_DATA_W-1:0] edata,
                                        bit [ROLE_W-1:0] role);
    request_t r;
    r.req_type = t;
    r.req_term = term;
    r.peer_id = peer;
    r.ref_index = idx[REF_INDEX_W-1:0];
    r.ref_term = rterm;
    r.has_entry = has;
    r.entry_term = eterm;
    r.entry_data = edata;
    r.current_role = role;
    return r;
  endfunction

  // Mostly well-formed leader traffic and elections against the current state.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       p;
    r.req_type = REQ_APPEND;
    r.req_term = sb.term_now + (($urandom_range(0, 9) == 0) ? 1 : 0);
    r.peer_id = ($urandom_range(0, 3) == 0) ? PEER_W'($urandom) : PEER_W'($urandom_range(0, 3));
    r.has_entry = ($urandom_range(0, 7) != 0);
    r.entry_term = ($urandom_range(0, 15) == 0) ? $urandom : r.req_term;
    r.entry_data = {$urandom, $urandom};
    r.current_role = ROLE_W'($urandom_range(0, 3));
    r.ref_index = REF_INDEX_W'(sb.held - 1);
    r.ref_term = sb.last_term();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // extend the log at its tail: keep defaults
    end else if (pick < 55) begin
      p = $urandom_range(0, sb.held);
      r.ref_index = REF_INDEX_W'(p - 1);
      r.ref_term = (p > 0 && $urandom_range(0, 3) != 0) ? sb.log_terms[p-1] : $urandom;
    end else if (pick < 80) begin
      r.req_type = REQ_VOTE;
      if ($urandom_range(0, 3) == 0)
        r.req_term = sb.term_now + 1;
      r.ref_index = REF_INDEX_W'(sb.held - 2 + int'($urandom_range(0, 2)));
      r.ref_term = sb.last_term() - 1 + $urandom_range(0, 2);
    end else if (pick < 90) begin
      if (sb.term_now > 0)
        r.req_term = $urandom % sb.term_now;
      r.req_type = 1'($urandom);
      r.ref_index = REF_INDEX_W'($urandom);
    end else begin
      r.req_type = 1'($urandom);
      r.ref_index = REF_INDEX_W'($urandom);
      r.ref_term = $urandom;
    end
    return r;
  endfunction

  task automatic send(request_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.req_type;
    in_req_term <= r.req_term;
    in_peer_id <= r.peer_id;
    in_ref_index <= r.ref_index;
    in_ref_term <= r.ref_term;
    in_has_entry <= r.has_entry;
    in_entry_term <= r.entry_term;
    in_entry_data <= r.entry_data;
    in_current_role <= r.current_role;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) send(random_request());
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(make_req(REQ_VOTE, 0, 5, -1, 0, 0, 0, 0, ROLE_CANDIDATE));
    send(make_req(REQ_VOTE, 0, 6, -1, 0, 0, 0, 0, ROLE_FOLLOWER));
    send(make_req(REQ_VOTE, 0, 5, -1, 0, 0, 0, 0, ROLE_LEADER));
    send(make_req(REQ_APPEND, 1, 0, -1, 0, 1, 1, '1, ROLE_CANDIDATE));
    send(make_req(REQ_APPEND, 1, 255, 0, 1, 0, 0, 0, ROLE_LEADER));
    send(make_req(REQ_APPEND, 1, 1, 0, 7, 1, 1, 1, ROLE_FOLLOWER));
    send(make_req(REQ_APPEND, 1, 1, 5, 1, 1, 1, 1, ROLE_FOLLOWER));
    send(make_req(REQ_APPEND, 1, 1, -2, 0, 1, 1, 1, ROLE_FOLLOWER));
    send(make_req(REQ_APPEND, 1, 1, -1024, 0, 1, 1, 1, ROLE_CANDIDATE));
    send(make_req(REQ_APPEND, 1, 1, 0, 1, 1, 2, 0, 2'd3));
    send(make_req(REQ_APPEND, 1, 1, 1, 2, 1, 3, 64'h1234, ROLE_LEADER));
    // candidate logs: older last term, shorter log, then up to date
    send(make_req(REQ_VOTE, 3, 9, 9, 2, 0, 0, 0, ROLE_LEADER));
    send(make_req(REQ_VOTE, 3, 9, 1, 3, 0, 0, 0, ROLE_CANDIDATE));
    send(make_req(REQ_VOTE, 3, 9, 2, 3, 0, 0, 0, ROLE_CANDIDATE));
    send(make_req(REQ_VOTE, 3, 10, 50, 4, 0, 0, 0, ROLE_FOLLOWER));
    send(make_req(REQ_VOTE, 1, 9, 2, 3, 0, 0, 0, ROLE_CANDIDATE));
    send(make_req(REQ_APPEND, 0, 1, 2, 3, 1, 0, 0, ROLE_LEADER));
    // cut back the log: matching, mismatching, then to empty
    send(make_req(REQ_APPEND, 3, 2, 0, 1, 1, 3, '1, ROLE_CANDIDATE));
    send(make_req(REQ_APPEND, 3, 2, 0, 9, 0, 0, 0, ROLE_FOLLOWER));
    send(make_req(REQ_APPEND, 3, 2, -1, 0, 0, 0, 0, 2'd3));
    send(make_req(REQ_VOTE, 4, 255, 1023, '1, 0, 0, 0, ROLE_LEADER));
    send(make_req(REQ_APPEND, 4, 0, 1023, 0, 1, 4, 0, ROLE_LEADER));

    run_random(150);
    hold_start = 1'b1;
    run_random(150);
    drain();
    run_random(200);

    send_idle_pct = 47;
    recv_idle_pct = 8;
    run_random(500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sb.held < LOG_DEPTH)
      send(make_req(REQ_APPEND, sb.term_now, 1, sb.held - 1, sb.last_term(), 1, sb.term_now,
                    {$urandom, $urandom}, ROLE_W'($urandom_range(0, 3))));
    // log is full: entries are refused, heartbeats and votes still answered
    send(make_req(REQ_APPEND, sb.term_now, 1, LOG_DEPTH - 1, sb.last_term(), 1, 0, '1,
                  ROLE_LEADER));
    send(make_req(REQ_APPEND, sb.term_now + 1, 1, LOG_DEPTH - 1, sb.last_term(), 1, 0, 0,
                  ROLE_CANDIDATE));
    send(make_req(REQ_APPEND, sb.term_now, 1, LOG_DEPTH - 1, sb.last_term(), 0, 0, 0,
                  ROLE_FOLLOWER));
    send(make_req(REQ_VOTE, sb.term_now, 3, LOG_DEPTH - 1, sb.last_term(), 0, 0, 0,
                  ROLE_CANDIDATE));
    send(make_req(REQ_APPEND, sb.term_now, 1, 299, sb.log_terms[299], 1, sb.term_now, 0,
                  ROLE_LEADER));
    run_random(300);

    // terms across the full range, ending at the largest term
    repeat (12) begin
      send(make_req(1'($urandom), $urandom, PEER_W'($urandom), sb.held - 1, sb.last_term(),
                    1'($urandom), $urandom, {$urandom, $urandom},
                    ROLE_W'($urandom_range(0, 3))));
    end
    send(make_req(REQ_VOTE, '1, 7, sb.held - 1, sb.last_term(), 0, 0, 0, ROLE_CANDIDATE));
    send(make_req(REQ_APPEND, '1, 7, sb.held - 1, sb.last_term(), 1, '1, '1, ROLE_LEADER));
    send(make_req(REQ_APPEND, '1, 7, sb.held - 1, sb.last_term(), 0, 0, 0, ROLE_FOLLOWER));
    send(make_req(REQ_VOTE, 0, 7, 0, 0, 0, 0, 0, ROLE_LEADER));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
design/cvar_pkg.sv
design/consensus_vote_and_append_responder_top.sv
test/consensus_vote_and_append_responder_top_tb.sv
